### sv/euler_angles_to_dcm_macros.svh
// assertion macros for the euler angle to dcm block
// used by the top level only; expects clk and arst_n in scope
`ifndef EULER_ANGLES_TO_DCM_MACROS_SVH
`define EULER_ANGLES_TO_DCM_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define EADCM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// implication checked in the same cycle
`define EADCM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### sv/eadcm_pkg.sv
// shared types, constants and tables for the euler angle to dcm block
// no dependencies; imported by every module of the block
`default_nettype none

package eadcm_pkg;

	localparam int DEF_ANGLE_WIDTH   = 16;
	localparam int DEF_ELEMENT_WIDTH = 16;
	localparam int QB                = 30;

	// pi/2 in q30 and its floor half
	localparam logic signed [35:0] HALF_PI_Q    = 36'sd1686629713;
	localparam logic signed [35:0] HALF_PI_HALF = HALF_PI_Q / 2;
	localparam logic [30:0]        T_ONE        = 31'd1 << QB;

	// horner steps; division by k is a multiply by ceil(2^s/k) then shift by s
	localparam int SIN_STEPS = 5;
	localparam int COS_STEPS = 6;
	localparam logic [30:0] SIN_MAGIC [SIN_STEPS] = '{
		31'd1249445032, 31'd1908874354, 31'd1636178018, 31'd1717986919, 31'd1431655766
	};
	localparam int SIN_SHIFT [SIN_STEPS] = '{37, 37, 36, 35, 33};
	localparam logic [30:0] COS_MAGIC [COS_STEPS] = '{
		31'd2082408386, 31'd1527099484, 31'd1227133514, 31'd1145324613,
		31'd1431655766, 31'd1073741824
	};
	localparam int COS_SHIFT [COS_STEPS] = '{38, 37, 36, 35, 34, 31};

	// register index on the config port
	localparam logic REG_ROT_SEQ = 1'b0;

	typedef enum logic [3:0] {
		SEQ_XYZ = 4'd0, SEQ_ZXZ = 4'd1, SEQ_XYX = 4'd2, SEQ_YZY = 4'd3,
		SEQ_ZYZ = 4'd4, SEQ_XZX = 4'd5, SEQ_YXY = 4'd6, SEQ_YZX = 4'd7,
		SEQ_ZXY = 4'd8, SEQ_XZY = 4'd9, SEQ_ZYX = 4'd10, SEQ_YXZ = 4'd11
	} seq_t;
	localparam int NUM_SEQ = 12;

	typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_t;

	typedef struct packed {
		axis_t a0;
		axis_t a1;
		axis_t a2;
	} axes_t;

	function automatic axes_t seq_axes(input logic [3:0] seq);
		axes_t ax;
		case (seq)
			SEQ_XYZ: ax = '{AXIS_X, AXIS_Y, AXIS_Z};
			SEQ_ZXZ: ax = '{AXIS_Z, AXIS_X, AXIS_Z};
			SEQ_XYX: ax = '{AXIS_X, AXIS_Y, AXIS_X};
			SEQ_YZY: ax = '{AXIS_Y, AXIS_Z, AXIS_Y};
			SEQ_ZYZ: ax = '{AXIS_Z, AXIS_Y, AXIS_Z};
			SEQ_XZX: ax = '{AXIS_X, AXIS_Z, AXIS_X};
			SEQ_YXY: ax = '{AXIS_Y, AXIS_X, AXIS_Y};
			SEQ_YZX: ax = '{AXIS_Y, AXIS_Z, AXIS_X};
			SEQ_ZXY: ax = '{AXIS_Z, AXIS_X, AXIS_Y};
			SEQ_XZY: ax = '{AXIS_X, AXIS_Z, AXIS_Y};
			SEQ_ZYX: ax = '{AXIS_Z, AXIS_Y, AXIS_X};
			SEQ_YXZ: ax = '{AXIS_Y, AXIS_X, AXIS_Z};
			default: ax = '{AXIS_X, AXIS_Y, AXIS_Z};
		endcase
		return ax;
	endfunction

	// one angle on its way through the series chain
	typedef struct packed {
		logic signed [31:0] r;
		logic [1:0]         quad;
		logic [29:0]        r2;
		logic [30:0]        ts;
		logic [30:0]        tc;
	} lane_t;

	typedef lane_t [2:0] lane_arr_t;

	typedef struct packed {
		logic      valid;
		lane_arr_t lanes;
	} lane_ch_t;

endpackage

`default_nettype wire

### sv/euler_angles_to_dcm.sv
// top level: config register, range reduction, series cell chain, matrix unit
// depends on eadcm_pkg, eadcm_reduce, eadcm_series_cell, eadcm_matrix
//
//   channel   | dir | word
//   s_axis    | in  | angle_first, angle_second, angle_third
//   m_axis    | out | elem_r1c1 .. elem_r3c3, row-major
//   apb       | in  | rotation_sequence at address 0
//
// one word per cycle while m_axis_tready is high; 4 reduction stages, 6 series cells
// of 2 stages each, 8 matrix stages ending in the output register
// every stage has its own valid bit, so bubbles close up behind a stalled output
// reset clears the valid bits and selects sequence xyz
`default_nettype none

module euler_angles_to_dcm
	import eadcm_pkg::*;
#(
	parameter int ANGLE_WIDTH   = DEF_ANGLE_WIDTH,
	parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	// angle_first, angle_second, angle_third, zero pad
	input  wire logic [((3*ANGLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	// elem_r1c1 .. elem_r3c3 row-major, zero pad
	output logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [2:0]                paddr,
	input  wire logic [31:0]               pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	localparam int OUT_W = ((9 * ELEMENT_WIDTH + 7) / 8) * 8;

	logic [3:0] seq_q;

	lane_ch_t ch [COS_STEPS+1];
	logic     rdy [COS_STEPS+1];

	logic [2:0][ANGLE_WIDTH-1:0]   angle;
	logic [8:0][ELEMENT_WIDTH-1:0] elem;
	logic                          elems_ok;
	logic signed [ELEMENT_WIDTH:0] ev;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ROT_SEQ) begin
			seq_q <= pwdata[3:0];
		end
	end

	assign prdata = (paddr[2] == REG_ROT_SEQ) ? 32'(seq_q) : '0;

	assign angle = s_axis_tdata[3*ANGLE_WIDTH-1:0];

	eadcm_reduce #(
		.ANGLE_WIDTH(ANGLE_WIDTH)
	) u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.angle    (angle),
		.out_ch   (ch[0]),
		.out_ready(rdy[0])
	);

	for (genvar g = 0; g < COS_STEPS; g++) begin : g_cell
		eadcm_series_cell #(
			.STEP(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_ch    (ch[g]),
			.in_ready (rdy[g]),
			.out_ch   (ch[g+1]),
			.out_ready(rdy[g+1])
		);
	end

	eadcm_matrix #(
		.ELEMENT_WIDTH(ELEMENT_WIDTH)
	) u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (ch[COS_STEPS]),
		.in_ready (rdy[COS_STEPS]),
		.rot_seq  (seq_q),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.elem     (elem)
	);

	assign m_axis_tdata = OUT_W'(elem);

	// every element lies within plus or minus one
	always_comb begin
		elems_ok = 1'b1;
		ev = '0;
		for (int e = 0; e < 9; e++) begin
			ev = $signed({elem[e][ELEMENT_WIDTH-1], elem[e]});
			if (ev > ((ELEMENT_WIDTH+1)'(1) <<< (ELEMENT_WIDTH - 2))
				|| ev < -((ELEMENT_WIDTH+1)'(1) <<< (ELEMENT_WIDTH - 2))) begin
				elems_ok = 1'b0;
			end
		end
	end

`include "euler_angles_to_dcm_macros.svh"

	`EADCM_ASSERT_IMPL(a_elem_range, m_axis_tvalid, elems_ok, "matrix element out of range")
	`EADCM_ASSERT_IMPL(a_stall_full, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled with room in the pipeline")

endmodule

`default_nettype wire

### sv/eadcm_reduce.sv
// range reduction: angle to q30, quadrant and residue, residue squared
// depends on eadcm_pkg
`default_nettype none

module eadcm_reduce
	import eadcm_pkg::*;
#(
	parameter int ANGLE_WIDTH = DEF_ANGLE_WIDTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [2:0][ANGLE_WIDTH-1:0] angle,
	output lane_ch_t                         out_ch,
	input  wire logic                        out_ready
);

	localparam int NST = 4;
	localparam int XS  = QB - (ANGLE_WIDTH - 4);

	logic [NST-1:0] vld_q;
	logic [NST:0]   adv;

	logic [34:0]        y_s1 [3];
	logic [34:0]        y_s2 [3];
	logic [3:0]         n_s2 [3];
	logic signed [31:0] r_s3 [3];
	logic [1:0]         quad_s3 [3];
	lane_arr_t          lane_s4;

	logic [34:0]        y_nx [3];
	logic [3:0]         n_nx [3];
	logic signed [31:0] r_nx [3];
	lane_arr_t          lane_nx;
	logic signed [35:0] xw;
	logic signed [35:0] rw;
	logic signed [63:0] sq;

	always_comb begin
		adv[NST] = out_ready;
		for (int k = NST - 1; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_ready     = adv[0];
	assign out_ch.valid = vld_q[NST-1];
	assign out_ch.lanes = lane_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_comb begin
		xw = '0;
		rw = '0;
		sq = '0;
		for (int l = 0; l < 3; l++) begin
			// shift to q30 and add 8 quadrants so the value is positive
			xw = 36'($signed(angle[l])) <<< XS;
			y_nx[l] = 35'(xw + (HALF_PI_Q <<< 3));
			// nearest multiple of pi/2
			n_nx[l] = '0;
			for (int k = 1; k < 16; k++) begin
				if ($signed({1'b0, y_s1[l]}) >= 36'(k) * HALF_PI_Q - HALF_PI_HALF) begin
					n_nx[l] = 4'(k);
				end
			end
			rw = $signed({1'b0, y_s2[l]}) - $signed({32'd0, n_s2[l]}) * HALF_PI_Q;
			r_nx[l] = 32'(rw);
			sq = r_s3[l] * r_s3[l];
			lane_nx[l].r    = r_s3[l];
			lane_nx[l].quad = quad_s3[l];
			lane_nx[l].r2   = sq[59:30];
			lane_nx[l].ts   = T_ONE;
			lane_nx[l].tc   = T_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			y_s1 <= y_nx;
		end
		if (adv[1]) begin
			y_s2 <= y_s1;
			n_s2 <= n_nx;
		end
		if (adv[2]) begin
			r_s3 <= r_nx;
			for (int l = 0; l < 3; l++) begin
				quad_s3[l] <= n_s2[l][1:0];
			end
		end
		if (adv[3]) begin
			lane_s4 <= lane_nx;
		end
	end

endmodule

`default_nettype wire

### sv/eadcm_series_cell.sv
// one horner step of the cosine series, and of the sine series where DO_SIN is set, for all three angles
// depends on eadcm_pkg; cells are chained by the top level
`default_nettype none

module eadcm_series_cell
	import eadcm_pkg::*;
#(
	parameter int STEP = 0
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire lane_ch_t in_ch,
	output logic          in_ready,
	output lane_ch_t      out_ch,
	input  wire logic     out_ready
);

	localparam int  NST     = 2;
	localparam bit  DO_SIN  = STEP >= COS_STEPS - SIN_STEPS;
	localparam int  SIN_IDX = DO_SIN ? STEP - (COS_STEPS - SIN_STEPS) : 0;

	logic [NST-1:0] vld_q;
	logic [NST:0]   adv;

	lane_arr_t   lane_s1;
	logic [29:0] pc_s1 [3];
	logic [29:0] ps_s1 [3];
	lane_arr_t   lane_s2;

	logic [29:0] pc_nx [3];
	logic [29:0] ps_nx [3];
	lane_arr_t   lane_nx;
	logic [60:0] mc;
	logic [60:0] ms;

	always_comb begin
		adv[NST] = out_ready;
		for (int k = NST - 1; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_ready     = adv[0];
	assign out_ch.valid = vld_q[NST-1];
	assign out_ch.lanes = lane_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_ch.valid;
			end
			if (adv[1]) begin
				vld_q[1] <= vld_q[0];
			end
		end
	end

	always_comb begin
		mc = '0;
		ms = '0;
		lane_nx = lane_s1;
		for (int l = 0; l < 3; l++) begin
			mc = 61'(in_ch.lanes[l].r2) * 61'(in_ch.lanes[l].tc);
			pc_nx[l] = mc[59:30];
			ms = 61'(in_ch.lanes[l].r2) * 61'(in_ch.lanes[l].ts);
			ps_nx[l] = ms[59:30];
		end
		for (int l = 0; l < 3; l++) begin
			mc = 61'(pc_s1[l]) * 61'(COS_MAGIC[STEP]);
			lane_nx[l].tc = T_ONE - 31'(mc >> COS_SHIFT[STEP]);
			ms = 61'(ps_s1[l]) * 61'(SIN_MAGIC[SIN_IDX]);
			if (DO_SIN) begin
				lane_nx[l].ts = T_ONE - 31'(ms >> SIN_SHIFT[SIN_IDX]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			lane_s1 <= in_ch.lanes;
			pc_s1   <= pc_nx;
			ps_s1   <= ps_nx;
		end
		if (adv[1]) begin
			lane_s2 <= lane_nx;
		end
	end

endmodule

`default_nettype wire

### sv/eadcm_matrix.sv
// sine finish, quadrant fold, elementary matrices, two 3x3 products,
// output rounding and saturation; depends on eadcm_pkg
`default_nettype none

module eadcm_matrix
	import eadcm_pkg::*;
#(
	parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lane_ch_t                      in_ch,
	output logic                               in_ready,
	input  wire logic [3:0]                    rot_seq,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [8:0][ELEMENT_WIDTH-1:0]      elem
);

	localparam int NST = 8;
	localparam int SH  = QB - (ELEMENT_WIDTH - 2);
	localparam logic signed [35:0] RND = (36'sd1 <<< SH) >>> 1;
	localparam logic signed [35:0] LIM = 36'sd1 <<< (ELEMENT_WIDTH - 2);
	localparam logic signed [31:0] ONE = 32'sd1 <<< QB;

	logic [NST-1:0] vld_q;
	logic [NST:0]   adv;

	logic signed [63:0] sp_s1 [3];
	logic [30:0]        tc_s1 [3];
	logic [1:0]         quad_s1 [3];
	logic signed [31:0] s_s2 [3];
	logic signed [31:0] c_s2 [3];
	logic signed [31:0] ma_s3 [3][3];
	logic signed [31:0] mb_s3 [3][3];
	logic signed [31:0] mc_s3 [3][3];
	logic signed [63:0] p1_s4 [3][3][3];
	logic signed [31:0] mc_s4 [3][3];
	logic signed [32:0] ab_s5 [3][3];
	logic signed [31:0] mc_s5 [3][3];
	logic signed [63:0] p2_s6 [3][3][3];
	logic signed [34:0] m_s7 [3][3];
	logic [8:0][ELEMENT_WIDTH-1:0] elem_s8;

	logic signed [31:0] s_nx [3];
	logic signed [31:0] c_nx [3];
	logic signed [31:0] sr;
	logic signed [31:0] cr;
	logic signed [63:0] sr_w;
	logic signed [31:0] mat_nx [3][3][3];
	logic signed [31:0] ang_s;
	logic signed [31:0] ang_c;
	axis_t              ax [3];
	axes_t              axs;
	logic               seq_ok;
	logic signed [32:0] ab_nx [3][3];
	logic signed [34:0] m_nx [3][3];
	logic signed [65:0] sum;
	logic signed [35:0] v;
	logic [8:0][ELEMENT_WIDTH-1:0] elem_nx;

	always_comb begin
		adv[NST] = out_ready;
		for (int k = NST - 1; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[NST-1];
	assign elem      = elem_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_ch.valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// sine rounding and quadrant fold
	always_comb begin
		sr_w = '0;
		sr = '0;
		cr = '0;
		for (int l = 0; l < 3; l++) begin
			sr_w = (sp_s1[l] + 64'sd536870912) >>> QB;
			sr = 32'(sr_w);
			cr = $signed({1'b0, tc_s1[l]});
			case (quad_s1[l])
				2'd0: begin
					s_nx[l] = sr;
					c_nx[l] = cr;
				end
				2'd1: begin
					s_nx[l] = cr;
					c_nx[l] = -sr;
				end
				2'd2: begin
					s_nx[l] = -sr;
					c_nx[l] = -cr;
				end
				default: begin
					s_nx[l] = -cr;
					c_nx[l] = sr;
				end
			endcase
		end
	end

	// elementary frame rotations; unused sequence codes give identity
	always_comb begin
		axs = seq_axes(rot_seq);
		seq_ok = rot_seq < 4'(NUM_SEQ);
		ax[0] = axs.a0;
		ax[1] = axs.a1;
		ax[2] = axs.a2;
		ang_s = '0;
		ang_c = '0;
		for (int l = 0; l < 3; l++) begin
			ang_s = s_s2[l];
			ang_c = c_s2[l];
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					mat_nx[l][i][j] = (i == j) ? ONE : 32'sd0;
				end
			end
			if (seq_ok) begin
				case (ax[l])
					AXIS_X: begin
						mat_nx[l][1][1] = ang_c;
						mat_nx[l][2][2] = ang_c;
						mat_nx[l][1][2] = ang_s;
						mat_nx[l][2][1] = -ang_s;
					end
					AXIS_Y: begin
						mat_nx[l][2][2] = ang_c;
						mat_nx[l][0][0] = ang_c;
						mat_nx[l][2][0] = ang_s;
						mat_nx[l][0][2] = -ang_s;
					end
					AXIS_Z: begin
						mat_nx[l][0][0] = ang_c;
						mat_nx[l][1][1] = ang_c;
						mat_nx[l][0][1] = ang_s;
						mat_nx[l][1][0] = -ang_s;
					end
					default: begin
						mat_nx[l][0][0] = ONE;
					end
				endcase
			end
		end
	end

	// sums of three products, rounded to q30, then to the output format
	always_comb begin
		sum = '0;
		v = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				sum = 66'(p1_s4[i][j][0]) + 66'(p1_s4[i][j][1]) + 66'(p1_s4[i][j][2])
					+ 66'sd536870912;
				ab_nx[i][j] = 33'(sum >>> QB);
				sum = 66'(p2_s6[i][j][0]) + 66'(p2_s6[i][j][1]) + 66'(p2_s6[i][j][2])
					+ 66'sd536870912;
				m_nx[i][j] = 35'(sum >>> QB);
				v = (36'(m_s7[i][j]) + RND) >>> SH;
				if (v > LIM) begin
					v = LIM;
				end
				if (v < -LIM) begin
					v = -LIM;
				end
				elem_nx[i*3+j] = ELEMENT_WIDTH'(v);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int l = 0; l < 3; l++) begin
				sp_s1[l]   <= $signed(in_ch.lanes[l].r) * $signed({1'b0, in_ch.lanes[l].ts});
				tc_s1[l]   <= in_ch.lanes[l].tc;
				quad_s1[l] <= in_ch.lanes[l].quad;
			end
		end
		if (adv[1]) begin
			s_s2 <= s_nx;
			c_s2 <= c_nx;
		end
		if (adv[2]) begin
			ma_s3 <= mat_nx[0];
			mb_s3 <= mat_nx[1];
			mc_s3 <= mat_nx[2];
		end
		if (adv[3]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						p1_s4[i][j][k] <= ma_s3[i][k] * mb_s3[k][j];
					end
				end
			end
			mc_s4 <= mc_s3;
		end
		if (adv[4]) begin
			ab_s5 <= ab_nx;
			mc_s5 <= mc_s4;
		end
		if (adv[5]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						p2_s6[i][j][k] <= 64'(ab_s5[i][k] * 65'(mc_s5[k][j]));
					end
				end
			end
		end
		if (adv[6]) begin
			m_s7 <= m_nx;
		end
		if (adv[7]) begin
			elem_s8 <= elem_nx;
		end
	end

endmodule

`default_nettype wire

### sim/euler_angles_to_dcm_test.sv
// testbench for euler_angles_to_dcm: angle words in, nine-element dcm words out
// a scoreboard class predicts each matrix in fixed point; depends on eadcm_pkg
`timescale 1ns / 100ps

module euler_angles_to_dcm_test
	import eadcm_pkg::*;
;

	typedef longint mat_t [3][3];

	localparam longint Q_ONE = 64'sd1 << 30;
	localparam longint HALF_PI = 64'sd1686629713;
	localparam longint ELEM_LIM = 64'sd16384;
	localparam logic [2:0] ADDR_ROT_SEQ = 3'(REG_ROT_SEQ) * 3'd4;
	localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

	class dcm_scoreboard;
		logic [143:0] pending [$];
		logic [3:0] seq;
		int errors;

		function new();
			seq = SEQ_XYZ;
			errors = 0;
		endfunction

		function longint rnd_shift(longint v, int sh);
			return (v + (64'sd1 <<< (sh - 1))) >>> sh;
		endfunction

		function longint horner(longint unsigned r2, int k0, int k1, int k2, int k3,
				int k4, int k5, int steps);
			longint unsigned t;
			int ks [6];
			ks = '{k0, k1, k2, k3, k4, k5};
			t = Q_ONE;
			for (int i = 0; i < steps; i++)
				t = Q_ONE - ((r2 * t) >> 30) / ks[i];
			return longint'(t);
		endfunction

		function mat_t rotation(axis_t axis, logic signed [15:0] ang);
			mat_t m;
			longint x, r, sr, cr, s, c;
			longint unsigned y, n, r2;
			int i, j;
			x = longint'(ang) * (64'sd1 << 18);
			y = x + 8 * HALF_PI;
			n = (y + HALF_PI / 2) / HALF_PI;
			r = longint'(y) - longint'(n * HALF_PI);
			r2 = longint'(r * r) >>> 30;
			sr = rnd_shift(r * horner(r2, 110, 72, 42, 20, 6, 1, 5), 30);
			cr = horner(r2, 132, 90, 56, 30, 12, 2, 6);
			case (n[1:0])
				2'd0: begin s = sr; c = cr; end
				2'd1: begin s = cr; c = -sr; end
				2'd2: begin s = -sr; c = -cr; end
				default: begin s = -cr; c = sr; end
			endcase
			i = (int'(axis) + 1) % 3;
			j = (int'(axis) + 2) % 3;
			foreach (m[a, b]) m[a][b] = 0;
			m[axis][axis] = Q_ONE;
			m[i][i] = c;
			m[j][j] = c;
			m[i][j] = s;
			m[j][i] = -s;
			return m;
		endfunction

		function mat_t product(mat_t a, mat_t b);
			mat_t p;
			longint acc;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					acc = 0;
					for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
					p[i][j] = rnd_shift(acc, 30);
				end
			return p;
		endfunction

		function void note_angles(logic [47:0] word);
			axis_t ax [3];
			mat_t m;
			longint v;
			logic [143:0] exp_word;
			case (seq)
				SEQ_XYZ: ax = '{AXIS_X, AXIS_Y, AXIS_Z};
				SEQ_ZXZ: ax = '{AXIS_Z, AXIS_X, AXIS_Z};
				SEQ_XYX: ax = '{AXIS_X, AXIS_Y, AXIS_X};
				SEQ_YZY: ax = '{AXIS_Y, AXIS_Z, AXIS_Y};
				SEQ_ZYZ: ax = '{AXIS_Z, AXIS_Y, AXIS_Z};
				SEQ_XZX: ax = '{AXIS_X, AXIS_Z, AXIS_X};
				SEQ_YXY: ax = '{AXIS_Y, AXIS_X, AXIS_Y};
				SEQ_YZX: ax = '{AXIS_Y, AXIS_Z, AXIS_X};
				SEQ_ZXY: ax = '{AXIS_Z, AXIS_X, AXIS_Y};
				SEQ_XZY: ax = '{AXIS_X, AXIS_Z, AXIS_Y};
				SEQ_ZYX: ax = '{AXIS_Z, AXIS_Y, AXIS_X};
				SEQ_YXZ: ax = '{AXIS_Y, AXIS_X, AXIS_Z};
				default: ax = '{AXIS_X, AXIS_X, AXIS_X};
			endcase
			if (seq < NUM_SEQ)
				m = product(product(rotation(ax[0], word[15:0]), rotation(ax[1], word[31:16])),
					rotation(ax[2], word[47:32]));
			else
				// unused codes give the identity
				foreach (m[a, b]) m[a][b] = (a == b) ? Q_ONE : 0;
			for (int k = 0; k < 9; k++) begin
				v = rnd_shift(m[k / 3][k % 3], 16);
				if (v > ELEM_LIM) v = ELEM_LIM;
				if (v < -ELEM_LIM) v = -ELEM_LIM;
				exp_word[16*k +: 16] = v[15:0];
			end
			pending.push_back(exp_word);
		endfunction

		function void check_matrix(logic [143:0] word);
			logic [143:0] exp_word;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected word %h", $time, word);
				return;
			end
			exp_word = pending.pop_front();
			for (int k = 0; k < 9; k++)
				if (word[16*k +: 16] !== exp_word[16*k +: 16]) begin
					errors++;
					$display("%0t: elem_r%0dc%0d expected %0d actual %0d", $time, k / 3 + 1,
						k % 3 + 1, $signed(exp_word[16*k +: 16]), $signed(word[16*k +: 16]));
				end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// angle_first, angle_second, angle_third
	logic [47:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// elem_r1c1 .. elem_r3c3 row-major
	logic [143:0] m_axis_tdata;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic calm = 1'b0;
	dcm_scoreboard board = new();

	euler_angles_to_dcm dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready) board.check_matrix(m_axis_tdata);

	always @(posedge clk)
		m_axis_tready <= calm || ($urandom_range(99) >= 13);

	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_ROT_SEQ) board.seq = value[3:0];
	endtask

	task automatic send_angles(logic [15:0] a1, logic [15:0] a2, logic [15:0] a3);
		// single idle cycle now and then
		if (!calm && $urandom_range(99) < 15) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {a3, a2, a1};
		do @(posedge clk); while (!s_axis_tready);
		board.note_angles({a3, a2, a1});
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		wait (board.pending.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_angle();
		case ($urandom_range(3))
			0: return 16'($urandom_range(12868)) - 16'd6434;	// within a quarter turn either side of zero
			1: return 16'($urandom_range(4)) * 16'd6434 + 16'($urandom_range(2)) - 16'd12869;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] ext [8];
		ext = '{16'h0000, 16'h8000, 16'h7fff, 16'hffff, 16'h0001, 16'd6434, -16'sd6434,
			16'd12868};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// reset sequence is xyz: directed extremes and quarter turns
		for (int i = 0; i < 8; i++) send_angles(ext[i], ext[(i + 3) % 8], ext[(i + 5) % 8]);
		send_angles(16'h5555, 16'haaaa, 16'h5a5a);
		send_angles(16'haaaa, 16'h5555, 16'ha5a5);
		drain();
		write_reg(ADDR_UNMAPPED, 32'd5);	// ignored, sequence stays xyz
		send_angles(16'd1000, 16'd2000, 16'd3000);
		drain();
		for (int s = 0; s < 16; s++) begin
			// upper bits of the write data are dropped
			write_reg(ADDR_ROT_SEQ, {$urandom_range(1) ? 28'hfffffff : 28'h0, 4'(s)});
			send_angles(ext[s % 8], ext[(s + 1) % 8], ext[(s + 2) % 8]);
			calm = (s == 6);
			for (int n = 0; n < 100; n++) send_angles(pick_angle(), pick_angle(), pick_angle());
			calm = 1'b0;
			drain();
		end
		write_reg(ADDR_ROT_SEQ, 32'(SEQ_XYZ));
		for (int n = 0; n < 10; n++) send_angles(pick_angle(), pick_angle(), pick_angle());
		drain();
		repeat (40) @(posedge clk);
		if (board.errors == 0)
			$display("euler_angles_to_dcm_test: clean");
		else
			$display("euler_angles_to_dcm_test: errors");
		$finish;
	end

	initial begin
		#4000000;
		$display("euler_angles_to_dcm_test: errors");
		$finish;
	end
endmodule

### euler_angles_to_dcm.f
+incdir+sv
sv/eadcm_pkg.sv
sv/eadcm_reduce.sv
sv/eadcm_series_cell.sv
sv/eadcm_matrix.sv
sv/euler_angles_to_dcm.sv
sim/euler_angles_to_dcm_test.sv
